// File: rtl/core/window_variance_3x3_macros.svh
// ---------------------------------------------------------------------------
// window_variance_3x3 assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef WINDOW_VARIANCE_3X3_MACROS_SVH
`define WINDOW_VARIANCE_3X3_MACROS_SVH

// check that prop holds at every clock edge out of reset
`define WV3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that post holds in the cycle after pre
`define WV3_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/core/wv3_pkg.sv
// ---------------------------------------------------------------------------
// wv3_pkg
// Widths, register codes and shared types for the 3x3 window variance block.
// ---------------------------------------------------------------------------
package wv3_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned VAR_W     = 37;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned LINE_AW   = $clog2(MAX_WIDTH);
  localparam int unsigned WIN       = 3;
  localparam int unsigned WIN_N     = WIN * WIN;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned MID_AW    = $clog2(MID_DEPTH);
  localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);

  localparam int unsigned SUM_W = SAMPLE_W + 4;
  localparam int unsigned SQ_W  = 2 * SAMPLE_W;
  localparam int unsigned QS_W  = SQ_W + 2;
  localparam int unsigned SS_W  = VAR_W + 1;

  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);
  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(4096);
  localparam logic [DIM_W-1:0] WIDTH_MAX = (MAX_WIDTH < 4096) ? DIM_W'(MAX_WIDTH) : DIM_MAX;
  localparam logic [DIM_W-1:0] WIDTH_RST = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef logic [WIN_N-1:0][SAMPLE_W-1:0] win_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } meta_t;

  typedef struct packed {
    win_t  win;
    meta_t meta;
  } mid_entry_t;

  typedef struct packed {
    logic                 empty;
    logic [MID_CNT_W-1:0] count;
  } mid_stat_t;

endpackage

// File: rtl/core/window_variance_3x3.sv
// ---------------------------------------------------------------------------
// window_variance_3x3
// Local 3x3 variance of a raster stream of signed Laplacian samples.
// ---------------------------------------------------------------------------
// Takes one sample per clock while full is low, in raster order, and
// returns, for every interior pixel, 9*sum(x^2) - (sum x)^2 over its 3x3
// neighborhood (divide by 81 for the variance); border pixels give no word.
// Sustained rate is one sample per cycle while full stays low. A sample
// completing its window passes through the registered read of the two line
// stores (4096 x 16 each, one read and one write port), the queue between
// intake and arithmetic, and the four multiply and add stages, the last of
// which holds the result word. full rises only when the four-entry queue
// between intake and arithmetic has no room left for the word in flight,
// which happens only while pop is held low.
// Writing either dimension register restarts the image at row 0, column 0.
// ---------------------------------------------------------------------------
module window_variance_3x3 import wv3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [COORD_W-1:0]   center_row_o,
  output logic [COORD_W-1:0]   center_col_o,
  output logic [VAR_W-1:0]     scaled_variance_o,
  output logic                 last_o
);

  mid_stat_t  q_stat;
  mid_entry_t q_in, q_out;
  logic       q_push, q_pop;

  wv3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .sample_i   (sample_i),
    .full_o     (full),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  wv3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .stat_o  (q_stat)
  );

  wv3_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_stat_i          (q_stat),
    .q_entry_i         (q_out),
    .q_pop_o           (q_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .center_row_o      (center_row_o),
    .center_col_o      (center_col_o),
    .scaled_variance_o (scaled_variance_o),
    .last_o            (last_o)
  );

endmodule

// File: rtl/core/wv3_front.sv
// ---------------------------------------------------------------------------
// wv3_front
// Sample intake: raster position, two line stores, 3x3 window, and the
// decision which windows are interior and go on to the arithmetic.
// ---------------------------------------------------------------------------
module wv3_front import wv3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 push_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 full_o,
  input  mid_stat_t            q_stat_i,
  output logic                 q_push_o,
  output mid_entry_t           q_entry_o
);

  logic [DIM_W-1:0]    width_q, height_q;
  logic [DIM_W-1:0]    w_eff, h_eff;
  logic [COORD_W-1:0]  row_q, col_q;
  logic [DIM_W-1:0]    col_next, row_next;
  logic                wrap_c, wrap_r;
  logic                accept;
  logic                cfg_hit;
  logic [LINE_AW-1:0]  addr;

  logic [SAMPLE_W-1:0] line1 [MAX_WIDTH];
  logic [SAMPLE_W-1:0] line2 [MAX_WIDTH];
  logic [SAMPLE_W-1:0] up1_q, up2_q;

  logic                s1_valid_q;
  logic                s1_emit_q;
  meta_t               s1_meta_q;
  logic [LINE_AW-1:0]  s1_addr_q;
  logic [SAMPLE_W-1:0] s1_x_q;

  win_t                win_q, win_n;
  logic [MID_CNT_W:0]  credit;

  always_comb begin
    unique case (cfg_idx_i)
      CFG_IMAGE_WIDTH:  cfg_hit = cfg_we_i;
      CFG_IMAGE_HEIGHT: cfg_hit = cfg_we_i;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (width_q > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = width_q;
    end
    if (height_q < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (height_q > DIM_MAX) begin
      h_eff = DIM_MAX;
    end else begin
      h_eff = height_q;
    end
  end

  assign credit   = {1'b0, q_stat_i.count} + (MID_CNT_W + 1)'(q_push_o);
  assign full_o   = credit >= (MID_CNT_W + 1)'(MID_DEPTH);
  assign accept   = push_i && !full_o;
  assign col_next = {1'b0, col_q} + DIM_W'(1);
  assign row_next = {1'b0, row_q} + DIM_W'(1);
  assign wrap_c   = col_next >= w_eff;
  assign wrap_r   = row_next >= h_eff;
  assign addr     = col_q[LINE_AW-1:0];

  // restart the image on a write to either dimension register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_hit) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (wrap_c) begin
        col_q <= '0;
        row_q <= wrap_r ? '0 : row_next[COORD_W-1:0];
      end else begin
        col_q <= col_next[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up1_q       <= line1[addr];
      line1[addr] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up2_q <= line2[addr];
    end
    if (s1_valid_q) begin
      line2[s1_addr_q] <= up1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q      <= (row_q >= COORD_W'(2)) && (col_q >= COORD_W'(2));
      s1_meta_q.row  <= row_q - COORD_W'(1);
      s1_meta_q.col  <= col_q - COORD_W'(1);
      s1_meta_q.last <= wrap_r && wrap_c;
      s1_addr_q      <= addr;
      s1_x_q         <= sample_i;
    end
  end

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      win_n[k*WIN]     = win_q[k*WIN + 1];
      win_n[k*WIN + 1] = win_q[k*WIN + 2];
    end
    win_n[WIN - 1]         = up2_q;
    win_n[2*WIN - 1]       = up1_q;
    win_n[WIN*WIN - 1]     = s1_x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_n;
    end
  end

  assign q_push_o       = s1_valid_q && s1_emit_q;
  assign q_entry_o.win  = win_n;
  assign q_entry_o.meta = s1_meta_q;

endmodule

// File: rtl/core/wv3_queue.sv
// ---------------------------------------------------------------------------
// wv3_queue
// Short first-in first-out queue of interior windows between front and back.
// ---------------------------------------------------------------------------
module wv3_queue import wv3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mid_entry_t entry_i,
  input  logic       pop_i,
  output mid_entry_t entry_o,
  output mid_stat_t  stat_o
);

  mid_entry_t           slot_q [MID_DEPTH];
  logic [MID_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [MID_CNT_W-1:0] count_q;
  logic                 do_push, do_pop;

  assign do_push = push_i && (count_q != MID_CNT_W'(MID_DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + MID_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + MID_AW'(1);
      end
      count_q <= count_q + MID_CNT_W'(do_push) - MID_CNT_W'(do_pop);
    end
  end

  assign entry_o      = slot_q[rd_ptr_q];
  assign stat_o.empty = count_q == '0;
  assign stat_o.count = count_q;

endmodule

// File: rtl/core/wv3_back.sv
// ---------------------------------------------------------------------------
// wv3_back
// Four-stage arithmetic pipeline: 9*sum(x^2) - (sum x)^2 per window, with
// the last stage as the result register.
// ---------------------------------------------------------------------------
module wv3_back import wv3_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mid_stat_t          q_stat_i,
  input  mid_entry_t         q_entry_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [COORD_W-1:0] center_row_o,
  output logic [COORD_W-1:0] center_col_o,
  output logic [VAR_W-1:0]   scaled_variance_o,
  output logic               last_o
);

  logic                         adv;
  logic                         a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  meta_t                        a_meta_q, b_meta_q, c_meta_q, d_meta_q;

  logic signed [SQ_W-1:0]       sq_s [WIN_N];
  logic [WIN_N-1:0][SQ_W-1:0]   sq_d, sq_q;
  logic signed [SUM_W-1:0]      s_d, s_q;

  logic [WIN-1:0][SQ_W-1:0]     p_d, p_q;
  logic signed [2*SUM_W-1:0]    ss_full;
  logic [SS_W-1:0]              ss_q, ss_c_q;

  logic [QS_W-1:0]              q_sum_q;
  logic [SS_W-1:0]              v_d;
  logic [VAR_W-1:0]             v_q;

  assign adv     = !d_valid_q || pop_i;
  assign q_pop_o = adv && !q_stat_i.empty;

  always_comb begin
    s_d = '0;
    for (int k = 0; k < WIN_N; k++) begin
      sq_s[k] = $signed(q_entry_i.win[k]) * $signed(q_entry_i.win[k]);
      sq_d[k] = sq_s[k];
      s_d     = s_d + $signed({{(SUM_W-SAMPLE_W){q_entry_i.win[k][SAMPLE_W-1]}},
                               q_entry_i.win[k]});
    end
  end

  always_comb begin
    for (int g = 0; g < WIN; g++) begin
      p_d[g] = sq_q[g*WIN] + sq_q[g*WIN + 1] + sq_q[g*WIN + 2];
    end
  end

  assign ss_full = s_q * s_q;
  assign v_d     = {1'b0, q_sum_q, 3'b000} + {4'b0000, q_sum_q} - ss_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= q_pop_o;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q     <= sq_d;
      s_q      <= s_d;
      a_meta_q <= q_entry_i.meta;
      p_q      <= p_d;
      ss_q     <= ss_full[SS_W-1:0];
      b_meta_q <= a_meta_q;
      q_sum_q  <= {2'b00, p_q[0]} + {2'b00, p_q[1]} + {2'b00, p_q[2]};
      ss_c_q   <= ss_q;
      c_meta_q <= b_meta_q;
      v_q      <= v_d[VAR_W-1:0];
      d_meta_q <= c_meta_q;
    end
  end

  assign empty_o           = !d_valid_q;
  assign center_row_o      = d_meta_q.row;
  assign center_col_o      = d_meta_q.col;
  assign scaled_variance_o = v_q;
  assign last_o            = d_meta_q.last;

endmodule

// File: rtl/core/wv3_checker.sv
// ---------------------------------------------------------------------------
// wv3_checker
// Port-level checks on the result side of window_variance_3x3.
// ---------------------------------------------------------------------------
`include "window_variance_3x3_macros.svh"

module wv3_checker import wv3_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [COORD_W-1:0] center_row_o,
  input logic [COORD_W-1:0] center_col_o,
  input logic [VAR_W-1:0]   scaled_variance_o,
  input logic               last_o
);

  `WV3_ASSERT_NEXT(a_word_held, !empty && !pop, !empty && $stable(scaled_variance_o) && $stable(last_o), "result word changed while stalled")
  `WV3_ASSERT(a_center_interior, empty || (center_row_o != '0 && center_col_o != '0), "border pixel emitted")
  `WV3_ASSERT(a_var_bound, empty || (scaled_variance_o <= VAR_W'(64'd86973087744)), "scaled variance beyond bound")
  `WV3_ASSERT(a_last_corner, empty || !last_o || (center_row_o >= COORD_W'(1) && center_col_o >= COORD_W'(1)), "last word off interior")

endmodule

bind window_variance_3x3 wv3_checker u_wv3_checker (.*);

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for window_variance_3x3.
// ---------------------------------------------------------------------------
// Streams signed samples through the push/full side and pops result words
// from the empty/pop side, with random idle bursts on both sides. A
// behavioral copy of the line stores, the 3x3 window and the raster position
// predicts each word. Every popped word is checked field by field against
// the oldest prediction. The run covers the reset dimensions, a short
// directed table, random small images with restarts and clamped sizes, a
// clamped full-width setting and a full-height setting.
// ---------------------------------------------------------------------------
module testbench;
  import wv3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_PAD = 16;
  localparam int REPORT_CAP  = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [VAR_W-1:0]   score;
    logic               last;
  } window_result_t;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     data;
    logic [SAMPLE_W-1:0]  sample;
    bit                   typed;
    logic [COORD_W-1:0]   exp_row;
    logic [COORD_W-1:0]   exp_col;
    logic [VAR_W-1:0]     exp_score;
    logic                 exp_last;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIM_W-1:0]     cfg_data_i;
  logic                 push;
  logic                 full;
  logic [SAMPLE_W-1:0]  sample_i;
  logic                 empty;
  logic                 pop;
  logic [COORD_W-1:0]   center_row_o;
  logic [COORD_W-1:0]   center_col_o;
  logic [VAR_W-1:0]     scaled_variance_o;
  logic                 last_o;

  window_variance_3x3 DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .push              (push),
    .full              (full),
    .sample_i          (sample_i),
    .empty             (empty),
    .pop               (pop),
    .center_row_o      (center_row_o),
    .center_col_o      (center_col_o),
    .scaled_variance_o (scaled_variance_o),
    .last_o            (last_o)
  );

  bit [SAMPLE_W-1:0] line_up1 [MAX_WIDTH];
  bit [SAMPLE_W-1:0] line_up2 [MAX_WIDTH];
  bit [SAMPLE_W-1:0] win_taps [WIN][WIN];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;

  window_result_t pending_windows [$];
  int gap_pct;
  int stall_pct;
  int samples_sent;
  int windows_seen;
  int cfg_writes;
  int mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("** window_variance_3x3: FAILED **");
    $finish;
  end

  function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic bit predict_variance(input logic [SAMPLE_W-1:0] x,
                                          output window_result_t res);
    int unsigned w, h, r, c;
    logic [SAMPLE_W-1:0] up1, up2;
    longint s, q, e;
    bit hit;
    w = dim_in_use(width_reg);
    h = dim_in_use(height_reg);
    r = cur_row;
    c = cur_col;
    up1 = line_up1[c % MAX_WIDTH];
    up2 = line_up2[c % MAX_WIDTH];
    for (int k = 0; k < WIN; k++) begin
      win_taps[k][0] = win_taps[k][1];
      win_taps[k][1] = win_taps[k][2];
    end
    win_taps[0][2] = up2;
    win_taps[1][2] = up1;
    win_taps[2][2] = x;
    line_up2[c % MAX_WIDTH] = up1;
    line_up1[c % MAX_WIDTH] = x;
    hit = 1'b0;
    res = '{default: '0};
    if (r >= 2 && c >= 2) begin
      s = 0;
      q = 0;
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          e = longint'($signed(win_taps[i][j]));
          s += e;
          q += e * e;
        end
      end
      res.row   = COORD_W'(r - 1);
      res.col   = COORD_W'(c - 1);
      res.score = VAR_W'(9 * q - s * s);
      res.last  = (r + 1 >= h) && (c + 1 >= w);
      hit = 1'b1;
    end
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : ((r + 1) & 12'hFFF);
    end else begin
      cur_col = (c + 1) & 12'hFFF;
    end
    return hit;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (sel < 40) return SAMPLE_W'(int'($urandom_range(16)) - 8);
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return DIM_W'($urandom_range(3, 10));
    if (sel < 90) return DIM_W'($urandom_range(0, 2));
    if (sel < 96) return DIM_W'($urandom_range(11, 48));
    return DIM_W'($urandom_range(4097, 8191));
  endfunction

  task automatic choose_idling();
    case ($urandom_range(2))
      0: gap_pct = 0;
      1: gap_pct = 10;
      default: gap_pct = 35;
    endcase
    case ($urandom_range(2))
      0: stall_pct = 0;
      1: stall_pct = 10;
      default: stall_pct = 35;
    endcase
  endtask

  task automatic wait_for_results();
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] data);
    push <= 1'b0;
    wait_for_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT) begin
      if (idx == CFG_IMAGE_WIDTH) width_reg = data;
      else height_reg = data;
      cur_row = 0;
      cur_col = 0;
    end
    cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input bit typed,
                             input window_result_t typed_res);
    window_result_t res;
    bit hit;
    int gap;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= x;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    hit = predict_variance(x, res);
    if (typed) pending_windows.push_back(typed_res);
    else if (hit) pending_windows.push_back(res);
    samples_sent++;
  endtask

  task automatic stream_samples(input int n);
    window_result_t none;
    none = '{default: '0};
    repeat (n) send_sample(pick_sample(), 1'b0, none);
  endtask

  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin : result_side
    int stall_left;
    window_result_t got, want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        got = '{center_row_o, center_col_o, scaled_variance_o, last_o};
        if (pending_windows.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: unexpected word: expected none, actual row %0d col %0d value %0d",
                     $time, got.row, got.col, got.score);
        end else begin
          want = pending_windows.pop_front();
          report_field("center_row", want.row, got.row);
          report_field("center_col", want.col, got.col);
          report_field("scaled_variance", want.score, got.score);
          report_field("last", want.last, got.last);
        end
        windows_seen++;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        pop <= 1'b0;
        stall_left = $urandom_range(7);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    plan_row_t directed_plan [21];
    window_result_t typed_res;
    int random_samples, phase, sel, area, n;
    logic [DIM_W-1:0] w, h;

    directed_plan = '{
      '{ROW_CFG,    CFG_IMAGE_WIDTH,  13'd3,    16'h0000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_CFG,    CFG_IMAGE_HEIGHT, 13'd3,    16'h0000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b1, 12'd1, 12'd1, 37'd0, 1'b1},
      '{ROW_SAMPLE, '0,               '0,       16'h7FFF, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h7FFF, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_CFG,    CFG_SPARE_LO,     13'h1FFF, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h7FFF, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h7FFF, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h8000, 1'b0, '0, '0, '0, 1'b0},
      '{ROW_SAMPLE, '0,               '0,       16'h7FFF, 1'b0, '0, '0, '0, 1'b0}
    };

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    push       = 1'b0;
    sample_i   = '0;
    pop        = 1'b0;
    cur_row    = 0;
    cur_col    = 0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    gap_pct    = 0;
    stall_pct  = 0;
    samples_sent   = 0;
    windows_seen   = 0;
    cfg_writes     = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset dimensions: part of the first row, no words expected
    choose_idling();
    stream_samples(40);

    gap_pct   = 10;
    stall_pct = 10;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_register(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        typed_res = '{directed_plan[i].exp_row, directed_plan[i].exp_col,
                      directed_plan[i].exp_score, directed_plan[i].exp_last};
        send_sample(directed_plan[i].sample, directed_plan[i].typed, typed_res);
      end
    end

    random_samples = 0;
    phase = 0;
    while (random_samples < 480) begin
      case (phase)
        0: begin
          w = 13'd0;
          h = 13'd1;
        end
        1: begin
          w = 13'd2;
          h = 13'h1FFF;
        end
        default: begin
          w = pick_dim();
          h = pick_dim();
        end
      endcase
      choose_idling();
      sel = $urandom_range(3);
      if (phase < 2 || sel != 0) write_register(CFG_IMAGE_WIDTH, w);
      if (phase < 2 || sel != 1) write_register(CFG_IMAGE_HEIGHT, h);
      if ($urandom_range(9) == 0)
        write_register($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, DIM_W'($urandom));
      area = dim_in_use(width_reg) * dim_in_use(height_reg);
      n = $urandom_range(1, 2) * area + $urandom_range(0, area / 2);
      if (n > 160) n = $urandom_range(40, 160);
      stream_samples(n);
      random_samples += n;
      phase++;
    end

    // full width, clamped from an oversized setting, start of the first row
    choose_idling();
    write_register(CFG_IMAGE_WIDTH, 13'h1FFF);
    write_register(CFG_IMAGE_HEIGHT, DIM_MIN);
    stream_samples(40);

    gap_pct   = 0;
    stall_pct = 0;
    write_register(CFG_IMAGE_WIDTH, DIM_MIN);
    write_register(CFG_IMAGE_HEIGHT, DIM_MAX);
    stream_samples(60);
    write_register(CFG_IMAGE_WIDTH, 13'd4);
    write_register(CFG_IMAGE_HEIGHT, 13'd3);
    stream_samples(4 * 3 * 2 + 5);

    push <= 1'b0;
    wait_for_results();

    $display("Run covered %0d samples, %0d result words and %0d register writes.",
             samples_sent, windows_seen, cfg_writes);
    $display("Sizes ran from 3x3 up to clamped 4096-wide and 4096-tall settings, with restarts.");
    if (mismatch_count == 0) begin
      $display("** window_variance_3x3: PASSED **");
    end else begin
      $display("** window_variance_3x3: FAILED **");
    end
    $finish;
  end

endmodule
